// ===== rtl/lsp_pkg.sv =====
// Package for the line sensor position estimator: sizes, register codes and shared types.
`timescale 1ns / 1ps
package lsp_pkg;

    localparam int CHANNELS   = 8;
    localparam int NUM_PORTS  = 8;
    localparam int SAMPLE_W   = 12;
    localparam int CFG_CNT_W  = 4;
    localparam int ERR_W      = 3;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    localparam int CNT_W      = $clog2(CHANNELS + 1);
    localparam int SUMW_W     = $clog2(CHANNELS * CHANNELS / 2 + 1) + 1;
    localparam int QW         = $clog2(CHANNELS / 2 + 1);
    localparam int STEP_W     = (QW > 1) ? $clog2(QW) : 1;

    localparam logic [SAMPLE_W-1:0]  SAMPLE_MAX    = '1;
    localparam logic [CFG_CNT_W-1:0] RST_COUNT     = CFG_CNT_W'(8);
    localparam logic [SAMPLE_W-1:0]  RST_THRESHOLD = SAMPLE_W'(2048);

    typedef enum logic [1:0] {
        REG_COUNT     = 2'd0,
        REG_INVERT    = 2'd1,
        REG_THRESHOLD = 2'd2
    } t_reg_idx;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } t_state;

    typedef struct packed {
        logic signed [SUMW_W-1:0] sum_w;
        logic [CNT_W-1:0]         sum_s;
    } t_merge;

    typedef struct packed {
        logic             busy;
        logic [ERR_W-1:0] err;
    } t_div_stat;

endpackage

// ===== rtl/lsp_lane.sv =====
// One channel lane: level correction, thresholding and next on-line state.
`timescale 1ns / 1ps
module lsp_lane (
    input  logic                           i_func,
    input  logic                           i_dbit,
    input  logic                           i_tmo,
    input  logic [lsp_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic                           i_invert,
    input  logic [lsp_pkg::SAMPLE_W-1:0]   i_threshold,
    input  logic                           i_counted,
    input  logic                           i_state,
    output logic [lsp_pkg::SAMPLE_W-1:0]   o_level,
    output logic                           o_state
);
    import lsp_pkg::*;

    logic                dig;
    logic [SAMPLE_W-1:0] corr;

    always_comb begin
        dig  = i_dbit ^ i_invert;
        corr = i_invert ? (SAMPLE_MAX - i_sample) : i_sample;
        o_level = '0;
        o_state = i_state;
        if (i_counted) begin
            if (!i_func) begin
                o_level = SAMPLE_W'(dig);
                o_state = dig;
            end else if (!i_tmo) begin
                o_level = corr;
                o_state = (corr > i_threshold);
            end
        end
    end

endmodule

// ===== rtl/lsp_merge.sv =====
// Merge of lane states: weighted sum, active count and off-track flag.
`timescale 1ns / 1ps
module lsp_merge (
    input  logic [lsp_pkg::CHANNELS-1:0] i_line,
    input  logic [lsp_pkg::CNT_W-1:0]    i_count,
    output lsp_pkg::t_merge              o_merge,
    output logic                         o_off
);
    import lsp_pkg::*;

    logic signed [SUMW_W-1:0] half;
    logic signed [SUMW_W-1:0] w;

    always_comb begin
        half = $signed(SUMW_W'(i_count >> 1));
        o_merge = '0;
        o_off = 1'b1;
        w = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            w = $signed(SUMW_W'(i)) - half;
            if (CNT_W'(i) < i_count) begin
                if (i_line[i]) begin
                    o_merge.sum_w = o_merge.sum_w + w;
                    o_merge.sum_s = o_merge.sum_s + CNT_W'(1);
                end
                if (i_line[i] != i_line[0]) begin
                    o_off = 1'b0;
                end
            end
        end
    end

endmodule

// ===== rtl/lsp_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
module lsp_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  lsp_pkg::t_merge     i_merge,
    output lsp_pkg::t_div_stat  o_stat
);
    import lsp_pkg::*;

    localparam int XW = SUMW_W + CNT_W + QW;

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic [SUMW_W-1:0] r_rem;
    logic [QW-1:0]     r_quo;
    logic [CNT_W-1:0]  r_dvs;
    logic              r_neg;
    logic              r_zero;

    logic [SUMW_W-1:0]   mag;
    logic [XW-1:0]       sh;
    logic                ge;
    logic [QW+ERR_W-1:0] qx;
    logic [QW+ERR_W-1:0] res;

    always_comb begin
        mag = i_merge.sum_w[SUMW_W-1] ? SUMW_W'(-i_merge.sum_w) : SUMW_W'(i_merge.sum_w);
        sh  = XW'(r_dvs) << r_step;
        ge  = (XW'(r_rem) >= sh);
        qx  = (QW+ERR_W)'(r_quo);
        res = r_neg ? (QW+ERR_W)'(-qx) : qx;
        o_stat.busy = r_busy;
        o_stat.err  = r_zero ? '0 : res[ERR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_step == '0)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_step <= STEP_W'(QW - 1);
            r_rem  <= mag;
            r_quo  <= '0;
            r_dvs  <= i_merge.sum_s;
            r_neg  <= i_merge.sum_w[SUMW_W-1];
            r_zero <= (i_merge.sum_s == '0);
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - sh[SUMW_W-1:0];
                r_quo[r_step] <= 1'b1;
            end
            if (r_step != '0) begin
                r_step <= r_step - STEP_W'(1);
            end
        end
    end

endmodule

// ===== rtl/line_sensor_position_estimator_top.sv =====
// Top level of the line sensor position estimator: APB registers, lanes, merge, divider, output.
// Throughput is set by the 3-step centroid divider plus the output load; result back-pressure can stall it.
// The next input is taken at the edge that loads the previous result into the output register.
// Reset is synchronous, active low: channel states clear, sensor_count 8, invert 0,
// threshold 2048, output register empty.
`timescale 1ns / 1ps
module line_sensor_position_estimator_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lsp_pkg::PADDR_W-1:0]  paddr,
    input  logic [lsp_pkg::PDATA_W-1:0]  pwdata,
    output logic [lsp_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_func,
    input  logic [7:0]                   i_digital_bits,
    input  logic [7:0]                   i_timeout_mask,
    input  logic [lsp_pkg::SAMPLE_W-1:0] i_sample_0,
    input  logic [lsp_pkg::SAMPLE_W-1:0] i_sample_1,
    input  logic [lsp_pkg::SAMPLE_W-1:0] i_sample_2,
    input  logic [lsp_pkg::SAMPLE_W-1:0] i_sample_3,
    input  logic [lsp_pkg::SAMPLE_W-1:0] i_sample_4,
    input  logic [lsp_pkg::SAMPLE_W-1:0] i_sample_5,
    input  logic [lsp_pkg::SAMPLE_W-1:0] i_sample_6,
    input  logic [lsp_pkg::SAMPLE_W-1:0] i_sample_7,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [7:0]                   o_line_bits,
    output logic signed [lsp_pkg::ERR_W-1:0] o_track_error,
    output logic                         o_off_track,
    output logic [lsp_pkg::SAMPLE_W-1:0] o_level_0,
    output logic [lsp_pkg::SAMPLE_W-1:0] o_level_1,
    output logic [lsp_pkg::SAMPLE_W-1:0] o_level_2,
    output logic [lsp_pkg::SAMPLE_W-1:0] o_level_3,
    output logic [lsp_pkg::SAMPLE_W-1:0] o_level_4,
    output logic [lsp_pkg::SAMPLE_W-1:0] o_level_5,
    output logic [lsp_pkg::SAMPLE_W-1:0] o_level_6,
    output logic [lsp_pkg::SAMPLE_W-1:0] o_level_7
);
    import lsp_pkg::*;

    logic [CFG_CNT_W-1:0] r_cfg_count;
    logic                 r_cfg_invert;
    logic [SAMPLE_W-1:0]  r_cfg_thr;

    t_state r_state;
    t_state n_state;

    logic [CHANNELS-1:0] r_line;
    logic [CHANNELS-1:0] n_line;
    logic [SAMPLE_W-1:0] r_lvl [NUM_PORTS];
    logic                r_off;

    logic                r_ovalid;
    logic [7:0]          r_obits;
    logic [ERR_W-1:0]    r_oerr;
    logic                r_ooff;
    logic [SAMPLE_W-1:0] r_olvl [NUM_PORTS];

    logic [SAMPLE_W-1:0] w_smp [NUM_PORTS];
    logic [SAMPLE_W-1:0] w_lvl [NUM_PORTS];
    logic [CNT_W-1:0]    w_count;
    logic                w_off;
    logic                accept;
    logic                load_out;
    logic                cfg_wr;
    t_merge              w_merge;
    t_div_stat           w_div;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count  <= RST_COUNT;
            r_cfg_invert <= 1'b0;
            r_cfg_thr    <= RST_THRESHOLD;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_COUNT:     r_cfg_count  <= pwdata[CFG_CNT_W-1:0];
                REG_INVERT:    r_cfg_invert <= pwdata[0];
                REG_THRESHOLD: r_cfg_thr    <= pwdata[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_COUNT:     prdata = PDATA_W'(r_cfg_count);
            REG_INVERT:    prdata = PDATA_W'(r_cfg_invert);
            REG_THRESHOLD: prdata = PDATA_W'(r_cfg_thr);
            default:       prdata = '0;
        endcase
    end

    assign w_count = (r_cfg_count > CFG_CNT_W'(CHANNELS)) ? CNT_W'(CHANNELS)
                                                          : CNT_W'(r_cfg_count);

    // lanes
    assign w_smp[0] = i_sample_0;
    assign w_smp[1] = i_sample_1;
    assign w_smp[2] = i_sample_2;
    assign w_smp[3] = i_sample_3;
    assign w_smp[4] = i_sample_4;
    assign w_smp[5] = i_sample_5;
    assign w_smp[6] = i_sample_6;
    assign w_smp[7] = i_sample_7;

    for (genvar g = 0; g < NUM_PORTS; g++) begin : g_lane
        if (g < CHANNELS) begin : g_on
            lsp_lane u_lane (
                .i_func      (i_func),
                .i_dbit      (i_digital_bits[g]),
                .i_tmo       (i_timeout_mask[g]),
                .i_sample    (w_smp[g]),
                .i_invert    (r_cfg_invert),
                .i_threshold (r_cfg_thr),
                .i_counted   (CNT_W'(g) < w_count),
                .i_state     (r_line[g]),
                .o_level     (w_lvl[g]),
                .o_state     (n_line[g])
            );
        end else begin : g_off
            assign w_lvl[g] = '0;
        end
    end

    lsp_merge u_merge (
        .i_line  (n_line),
        .i_count (w_count),
        .o_merge (w_merge),
        .o_off   (w_off)
    );

    lsp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_merge (w_merge),
        .o_stat  (w_div)
    );

    // control
    always_comb begin
        unique case (r_state)
            ST_IDLE: n_state = accept ? ST_RUN : ST_IDLE;
            ST_RUN:  n_state = (load_out && !accept) ? ST_IDLE : ST_RUN;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        load_out   = (r_state == ST_RUN) && !w_div.busy && (!r_ovalid || i_out_ready);
        o_in_ready = (r_state == ST_IDLE) || load_out;
        accept     = i_in_valid && o_in_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_line  <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_line <= n_line;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_lvl <= w_lvl;
            r_off <= w_off;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load_out) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_obits <= 8'(r_line);
            r_oerr  <= w_div.err;
            r_ooff  <= r_off;
            r_olvl  <= r_lvl;
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_line_bits   = r_obits;
    assign o_track_error = $signed(r_oerr);
    assign o_off_track   = r_ooff;
    assign o_level_0     = r_olvl[0];
    assign o_level_1     = r_olvl[1];
    assign o_level_2     = r_olvl[2];
    assign o_level_3     = r_olvl[3];
    assign o_level_4     = r_olvl[4];
    assign o_level_5     = r_olvl[5];
    assign o_level_6     = r_olvl[6];
    assign o_level_7     = r_olvl[7];

    a_accept_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_RUN))
        else $error("transfer did not start a run");

    a_ready_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && (r_state == ST_RUN)) |-> load_out)
        else $error("input ready in run without result load");

    a_load_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> !w_div.busy)
        else $error("result loaded while divider busy");

    a_valid_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == ST_RUN))
        else $error("result appeared without a run");

endmodule

// ===== test/position_checker.sv =====
// Checker for the line sensor position estimator: tracks config writes, predicts each result, compares.
`timescale 1ns / 1ps
module position_checker (
    input  logic                                                   i_clk,
    input  logic                                                   i_rst_n,
    input  logic                                                   psel,
    input  logic                                                   penable,
    input  logic                                                   pwrite,
    input  logic                                                   pready,
    input  logic [lsp_pkg::PADDR_W-1:0]                            paddr,
    input  logic [lsp_pkg::PDATA_W-1:0]                            pwdata,
    input  logic                                                   i_in_valid,
    input  logic                                                   i_in_ready,
    input  logic                                                   i_func,
    input  logic [7:0]                                             i_digital_bits,
    input  logic [7:0]                                             i_timeout_mask,
    input  logic [lsp_pkg::NUM_PORTS-1:0][lsp_pkg::SAMPLE_W-1:0]   i_samples,
    input  logic                                                   i_out_valid,
    input  logic                                                   i_out_ready,
    input  logic [7:0]                                             i_line_bits,
    input  logic signed [lsp_pkg::ERR_W-1:0]                       i_track_error,
    input  logic                                                   i_off_track,
    input  logic [lsp_pkg::NUM_PORTS-1:0][lsp_pkg::SAMPLE_W-1:0]   i_levels,
    output int                                                     o_fail_count,
    output int                                                     o_outstanding
);
    import lsp_pkg::*;

    typedef struct packed {
        logic [7:0]                         line_bits;
        logic signed [ERR_W-1:0]            track_error;
        logic                               off_track;
        logic [NUM_PORTS-1:0][SAMPLE_W-1:0] levels;
    } t_position;

    logic [CHANNELS-1:0]  on_line;
    logic [CFG_CNT_W-1:0] cfg_count;
    logic                 cfg_invert;
    logic [SAMPLE_W-1:0]  cfg_threshold;
    t_position            pending_positions[$];
    int                   result_idx;

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
        result_idx    = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("result %0d: %s", result_idx, msg);
        o_fail_count++;
    endtask

    // Updates the channel states from the sample on the input channel and builds the result.
    task automatic predict_position(output t_position res);
        int                  n;
        int                  sum_w;
        int                  sum_s;
        int                  err;
        logic [SAMPLE_W-1:0] s;
        res = '0;
        n = (cfg_count > CHANNELS) ? CHANNELS : int'(cfg_count);
        for (int i = 0; i < n; i++) begin
            if (i_func == 1'b0) begin
                on_line[i]     = i_digital_bits[i] ^ cfg_invert;
                res.levels[i]  = SAMPLE_W'(on_line[i]);
            end else if (!i_timeout_mask[i]) begin
                s = cfg_invert ? SAMPLE_MAX - i_samples[i] : i_samples[i];
                res.levels[i]  = s;
                on_line[i]     = (s > cfg_threshold);
            end
        end
        sum_w = 0;
        sum_s = 0;
        res.off_track = 1'b1;
        for (int i = 0; i < n; i++) begin
            if (on_line[i]) begin
                sum_w += i - n / 2;
                sum_s++;
            end
            if (on_line[i] != on_line[0])
                res.off_track = 1'b0;
        end
        err = (sum_s != 0) ? sum_w / sum_s : 0;
        res.track_error = ERR_W'(err);
        res.line_bits   = 8'(on_line);
    endtask

    always @(posedge i_clk) begin : compare_results
        t_position want;
        if (!i_rst_n) begin
            on_line       = '0;
            cfg_count     = RST_COUNT;
            cfg_invert    = 1'b0;
            cfg_threshold = RST_THRESHOLD;
            pending_positions.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[3:2]))
                    REG_COUNT:     cfg_count = pwdata[CFG_CNT_W-1:0];
                    REG_INVERT:    cfg_invert = pwdata[0];
                    REG_THRESHOLD: cfg_threshold = pwdata[SAMPLE_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_positions.size() == 0) begin
                    report_mismatch("result transfer with no expectation waiting");
                end else begin
                    want = pending_positions.pop_front();
                    if (i_line_bits != want.line_bits)
                        report_mismatch($sformatf("line_bits is %02h, expected %02h",
                                                  i_line_bits, want.line_bits));
                    if (i_track_error != want.track_error)
                        report_mismatch($sformatf("track_error is %0d, expected %0d",
                                                  i_track_error, want.track_error));
                    if (i_off_track != want.off_track)
                        report_mismatch($sformatf("off_track is %0b, expected %0b",
                                                  i_off_track, want.off_track));
                    for (int i = 0; i < NUM_PORTS; i++)
                        if (i_levels[i] != want.levels[i])
                            report_mismatch($sformatf("level_%0d is %0d, expected %0d",
                                                      i, i_levels[i], want.levels[i]));
                end
                result_idx++;
            end
            if (i_in_valid && i_in_ready) begin
                predict_position(want);
                pending_positions.push_back(want);
            end
        end
        o_outstanding = pending_positions.size();
    end

endmodule

// ===== test/testbench.sv =====
// Testbench top for the line sensor position estimator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
    import lsp_pkg::*;

    localparam int   CYCLE_LIMIT     = 200000;
    localparam int   PHASES          = 12;
    localparam int   ITEMS_PER_PHASE = 150;
    localparam int   SETTLE_CYCLES   = 8;
    localparam logic FUNC_DIGITAL    = 1'b0;
    localparam logic FUNC_ANALOG     = 1'b1;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic [PADDR_W-1:0]                 paddr;
    logic [PDATA_W-1:0]                 pwdata;
    logic [PDATA_W-1:0]                 prdata;
    logic                               pready;
    logic                               i_in_valid;
    logic                               o_in_ready;
    logic                               i_func;
    logic [7:0]                         i_digital_bits;
    logic [7:0]                         i_timeout_mask;
    logic [NUM_PORTS-1:0][SAMPLE_W-1:0] sample_bus;
    logic                               o_out_valid;
    logic                               i_out_ready;
    logic [7:0]                         o_line_bits;
    logic signed [ERR_W-1:0]            o_track_error;
    logic                               o_off_track;
    logic [NUM_PORTS-1:0][SAMPLE_W-1:0] level_bus;

    int                  fail_count;
    int                  outstanding;
    int                  cycle_count = 0;
    int                  in_gap_odds;
    int                  out_stall_odds;
    int                  stall_left;
    logic                cur_invert;
    logic [SAMPLE_W-1:0] cur_threshold;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    line_sensor_position_estimator_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_digital_bits(i_digital_bits),
        .i_timeout_mask(i_timeout_mask),
        .i_sample_0    (sample_bus[0]),
        .i_sample_1    (sample_bus[1]),
        .i_sample_2    (sample_bus[2]),
        .i_sample_3    (sample_bus[3]),
        .i_sample_4    (sample_bus[4]),
        .i_sample_5    (sample_bus[5]),
        .i_sample_6    (sample_bus[6]),
        .i_sample_7    (sample_bus[7]),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_line_bits   (o_line_bits),
        .o_track_error (o_track_error),
        .o_off_track   (o_off_track),
        .o_level_0     (level_bus[0]),
        .o_level_1     (level_bus[1]),
        .o_level_2     (level_bus[2]),
        .o_level_3     (level_bus[3]),
        .o_level_4     (level_bus[4]),
        .o_level_5     (level_bus[5]),
        .o_level_6     (level_bus[6]),
        .o_level_7     (level_bus[7])
    );

    position_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_digital_bits(i_digital_bits),
        .i_timeout_mask(i_timeout_mask),
        .i_samples     (sample_bus),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_line_bits   (o_line_bits),
        .i_track_error (o_track_error),
        .i_off_track   (o_off_track),
        .i_levels      (level_bus),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // Result-side backpressure: random stall bursts on i_out_ready.
    always @(negedge i_clk) begin
        if (!i_rst_n || out_stall_odds == 0) begin
            i_out_ready <= 1'b1;
            stall_left = 0;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else if ($urandom_range(1, 100) <= out_stall_odds) begin
            i_out_ready <= 1'b0;
            stall_left = $urandom_range(0, 2);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("testbench NOT OK");
        $finish;
    end

    task automatic write_reg(input t_reg_idx idx, input logic [PDATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input logic [CFG_CNT_W-1:0] count, input logic invert,
                             input logic [SAMPLE_W-1:0] threshold);
        write_reg(REG_COUNT, PDATA_W'(count));
        write_reg(REG_INVERT, PDATA_W'(invert));
        write_reg(REG_THRESHOLD, PDATA_W'(threshold));
        cur_invert    = invert;
        cur_threshold = threshold;
    endtask

    // Drop valid, wait for every result, then let the pipeline settle before a config write.
    task automatic drain;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic send_sample(input logic func, input logic [7:0] dbits,
                               input logic [7:0] tmask,
                               input logic [NUM_PORTS-1:0][SAMPLE_W-1:0] samples);
        int gap;
        gap = 0;
        if (in_gap_odds != 0 && $urandom_range(1, 100) <= in_gap_odds)
            gap = $urandom_range(1, 3);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_func         <= func;
        i_digital_bits <= dbits;
        i_timeout_mask <= tmask;
        sample_bus     <= samples;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_random_sample;
        logic                               func;
        logic [7:0]                         dbits;
        logic [7:0]                         tmask;
        logic [NUM_PORTS-1:0][SAMPLE_W-1:0] samples;
        int                                 v;
        int                                 width;
        func = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 1) == 0) begin
            dbits = 8'($urandom);
        end else begin
            // a contiguous line under the sensor bar
            width = $urandom_range(1, 3);
            dbits = 8'(((1 << width) - 1) << $urandom_range(0, 7));
            if (cur_invert)
                dbits = ~dbits;
        end
        case ($urandom_range(0, 3))
            0: tmask = '0;
            1: tmask = 8'($urandom);
            2: tmask = 8'(1 << $urandom_range(0, 7));
            default: tmask = 8'($urandom & $urandom);
        endcase
        for (int i = 0; i < NUM_PORTS; i++) begin
            case ($urandom_range(0, 3))
                0: samples[i] = SAMPLE_W'($urandom_range(0, 4095));
                1: samples[i] = $urandom_range(0, 1) ? SAMPLE_MAX : '0;
                default: begin
                    v = int'(cur_threshold) + int'($urandom_range(0, 4)) - 2;
                    if (v < 0)
                        v = 0;
                    if (v > 4095)
                        v = 4095;
                    samples[i] = cur_invert ? SAMPLE_MAX - SAMPLE_W'(v) : SAMPLE_W'(v);
                end
            endcase
        end
        send_sample(func, dbits, tmask, samples);
    endtask

    initial begin : stimulus
        logic [CFG_CNT_W-1:0] phase_counts [PHASES];
        logic [SAMPLE_W-1:0]  thr;
        phase_counts = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd2, 4'd8, 4'd5, 4'd7, 4'd9, 4'd3,
                         4'd4, 4'd6};
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        i_in_valid     = 1'b0;
        i_func         = FUNC_DIGITAL;
        i_digital_bits = '0;
        i_timeout_mask = '0;
        sample_bus     = '0;
        i_out_ready    = 1'b1;
        in_gap_odds    = 20;
        out_stall_odds = 20;
        stall_left     = 0;
        cur_invert     = 1'b0;
        cur_threshold  = RST_THRESHOLD;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration: all eight channels, no inversion, mid threshold
        send_sample(FUNC_DIGITAL, 8'h00, 8'hFF, '0);
        send_sample(FUNC_DIGITAL, 8'hFF, 8'h00, {NUM_PORTS{SAMPLE_MAX}});
        send_sample(FUNC_DIGITAL, 8'h01, 8'h00, '0);
        send_sample(FUNC_DIGITAL, 8'h80, 8'h00, '0);
        send_sample(FUNC_DIGITAL, 8'h18, 8'h00, '0);
        send_sample(FUNC_DIGITAL, 8'hA5, 8'h5A, '0);
        send_sample(FUNC_ANALOG, 8'hFF, 8'h00, '0);
        send_sample(FUNC_ANALOG, 8'h00, 8'h00, {NUM_PORTS{SAMPLE_MAX}});
        send_sample(FUNC_ANALOG, 8'h00, 8'h00, {NUM_PORTS{12'd2048}});
        send_sample(FUNC_ANALOG, 8'h00, 8'h00, {NUM_PORTS{12'd2049}});
        send_sample(FUNC_ANALOG, 8'h00, 8'hFF, '0);
        send_sample(FUNC_ANALOG, 8'h00, 8'h5A, {12'd4095, 12'd3510, 12'd2925, 12'd2340,
                                                12'd1755, 12'd1170, 12'd585, 12'd0});
        // no counted channel: nothing updates
        drain();
        configure(4'd0, 1'b0, RST_THRESHOLD);
        send_sample(FUNC_DIGITAL, 8'h00, 8'h00, '0);
        send_sample(FUNC_ANALOG, 8'h00, 8'h00, '0);
        // single channel, inverted, lowest threshold
        drain();
        configure(4'd1, 1'b1, 12'd0);
        send_sample(FUNC_DIGITAL, 8'h00, 8'h00, '0);
        send_sample(FUNC_ANALOG, 8'h00, 8'h00, '0);
        send_sample(FUNC_ANALOG, 8'h00, 8'h00, {NUM_PORTS{SAMPLE_MAX}});
        // count above channel number saturates; top threshold keeps all analog channels off
        drain();
        configure(4'd15, 1'b0, SAMPLE_MAX);
        send_sample(FUNC_DIGITAL, 8'hF0, 8'h00, '0);
        send_sample(FUNC_ANALOG, 8'h00, 8'h00, {NUM_PORTS{SAMPLE_MAX}});
        drain();
        configure(4'd3, 1'b1, SAMPLE_MAX);
        send_sample(FUNC_ANALOG, 8'h00, 8'h00, '0);

        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p % 4)
                0: thr = SAMPLE_W'($urandom_range(0, 4095));
                1: thr = '0;
                2: thr = SAMPLE_MAX;
                default: thr = RST_THRESHOLD;
            endcase
            configure(phase_counts[p], 1'(p % 2), thr);
            if (p == PHASES - 1 || p % 4 == 3) begin
                in_gap_odds    = 0;
                out_stall_odds = 0;
            end else begin
                in_gap_odds    = 15;
                out_stall_odds = 15;
            end
            repeat (ITEMS_PER_PHASE) send_random_sample();
        end
        drain();

        if (fail_count == 0 && outstanding == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lsp_pkg.sv
rtl/lsp_lane.sv
rtl/lsp_merge.sv
rtl/lsp_div.sv
rtl/line_sensor_position_estimator_top.sv
test/position_checker.sv
test/testbench.sv
